>>> sv/tpi_pkg.sv
// ----------------------------------------------------------------------------
// tpi_pkg: shared definitions for the thrust to pulse interpolator
// Table constants, field widths, sequencer states and divider interface types.
// ----------------------------------------------------------------------------
package tpi_pkg;

	localparam int TABLE_POINTS = 18;
	localparam int IDX_W        = $clog2(TABLE_POINTS);

	localparam int FORCE_W = 16;            // signed Q8.8 thrust command
	localparam int PULSE_W = 11;            // pulse width in microseconds
	localparam int DIFF_W  = FORCE_W + 1;   // breakpoint and offset differences
	localparam int DY_W    = PULSE_W + 1;   // signed pulse difference
	localparam int NUM_W   = PULSE_W + DIFF_W;
	localparam int QUOT_W  = PULSE_W;       // quotient never exceeds the pulse step

	localparam logic signed [FORCE_W-1:0] BP_FORCE [TABLE_POINTS] = '{
		-16'sd10220, -16'sd8755, -16'sd6799, -16'sd5156, -16'sd3612, -16'sd2319,
		-16'sd1208,  -16'sd289,  -16'sd128,  16'sd0,     16'sd353,   16'sd1516,
		16'sd2921,   16'sd4580,  16'sd6566,  16'sd8589,  16'sd11164, 16'sd13171
	};

	localparam logic [PULSE_W-1:0] BP_PULSE [TABLE_POINTS] = '{
		11'd1100, 11'd1150, 11'd1200, 11'd1250, 11'd1300, 11'd1350,
		11'd1400, 11'd1450, 11'd1480, 11'd1520, 11'd1550, 11'd1600,
		11'd1650, 11'd1700, 11'd1750, 11'd1800, 11'd1850, 11'd1900
	};

	localparam logic [IDX_W-1:0] LAST_SEG = IDX_W'(TABLE_POINTS - 2);
	localparam logic [IDX_W-1:0] LAST_PT  = IDX_W'(TABLE_POINTS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_MUL,
		S_START,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [DIFF_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

>>> sv/tpi_div.sv
// ----------------------------------------------------------------------------
// tpi_div: serial restoring divider
// Produces one quotient bit per cycle; the quotient is known to fit QUOT_W bits.
// ----------------------------------------------------------------------------
module tpi_div import tpi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int DSH_W = DIFF_W + QUOT_W - 1;
	localparam int CNT_W = $clog2(QUOT_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  dsh_q;
	logic [QUOT_W-1:0] quot_q;
	logic              ge;

	// The shifted divisor is compared against the partial remainder.
	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// Completion is flagged for one cycle after the last quotient bit.
			done_q <= busy_q && !req.start && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			dsh_q  <= NUM_W'({req.den, {(QUOT_W - 1){1'b0}}});
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	// The divisor line must fit the remainder width.
	if (DSH_W > NUM_W) begin : g_width_check
		$error("tpi_div: divisor line wider than remainder");
	end

endmodule

>>> sv/thrust_to_pwm_interpolator_unit.sv
// ----------------------------------------------------------------------------
// thrust_to_pwm_interpolator_unit: thrust command to servo pulse width
// Piecewise linear interpolation over a fixed force to pulse table, with
// saturation at both ends and truncation to whole microseconds.
// ----------------------------------------------------------------------------
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------
//   input   | in_valid, in_stall  | force_q8_8  signed 16 bit Q8.8 thrust
//   output  | out_valid, out_stall| pulse_us    unsigned 11 bit microseconds
//
// A command at or beyond either end of the table is answered, once accepted,
// through the result and output registers. Otherwise the segment search
// walks the table one breakpoint per cycle, and a command in segment k
// passes the search of segments 0 to k, a multiply, a divider load, the
// divider (eleven quotient bits, one per cycle), res_q and out_pulse_q.
// The block holds in_stall high while an item is in work; the result sits in
// its own output register, so the next item is taken while it waits there.
// Reset is asynchronous and active low and clears the sequencer and out_valid.
// ----------------------------------------------------------------------------
module thrust_to_pwm_interpolator_unit import tpi_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [FORCE_W-1:0] force_q8_8,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic        [PULSE_W-1:0] pulse_us
);

	state_t state_q, state_d;

	// Item in work.
	logic signed [FORCE_W-1:0] v_q;
	logic        [IDX_W-1:0]   idx_q;
	logic        [PULSE_W-1:0] y0_q;
	logic signed [DY_W-1:0]    dy_q;
	logic        [DIFF_W-1:0]  off_q;
	logic        [DIFF_W-1:0]  dx_q;
	logic        [NUM_W-1:0]   num_q;
	logic        [PULSE_W-1:0] res_q;

	// Output register.
	logic               out_valid_q;
	logic [PULSE_W-1:0] out_pulse_q;

	logic accept;
	logic out_free;
	logic sat_low;
	logic sat_high;

	logic signed [FORCE_W-1:0] x_left;
	logic signed [FORCE_W-1:0] x_right;
	logic        [PULSE_W-1:0] y_left;
	logic        [PULSE_W-1:0] y_right;
	logic signed [DIFF_W-1:0]  dx;
	logic signed [DIFF_W-1:0]  off;
	logic signed [DY_W-1:0]    dy;
	logic                      hit;
	logic                      degenerate;

	// Control decisions made by the sequencer for the datapath.
	logic load_seg;
	logic load_res_seg;
	logic load_res_div;
	logic load_res_sat;
	logic step_idx;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Saturation is decided on the incoming command itself.
	assign sat_low  = (force_q8_8 <= BP_FORCE[0]);
	assign sat_high = (force_q8_8 >= BP_FORCE[LAST_PT]);

	// Segment under test: left point idx_q, right point idx_q + 1.
	assign x_left  = BP_FORCE[idx_q];
	assign x_right = BP_FORCE[idx_q + 1'b1];
	assign y_left  = BP_PULSE[idx_q];
	assign y_right = BP_PULSE[idx_q + 1'b1];

	assign hit = (v_q <= x_right);
	assign dx  = {x_right[FORCE_W-1], x_right} - {x_left[FORCE_W-1], x_left};
	assign off = {v_q[FORCE_W-1], v_q} - {x_left[FORCE_W-1], x_left};
	assign dy  = $signed({1'b0, y_right}) - $signed({1'b0, y_left});

	// A segment of no width, or a command left of the segment, takes the left
	// pulse width as it stands.
	assign degenerate = dx[DIFF_W-1] || (dx == '0) || off[DIFF_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		load_seg     = 1'b0;
		load_res_seg = 1'b0;
		load_res_div = 1'b0;
		load_res_sat = 1'b0;
		step_idx     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (sat_low || sat_high) begin
						load_res_sat = 1'b1;
						state_d      = S_DONE;
					end else begin
						state_d = S_SEARCH;
					end
				end
			end
			S_SEARCH: begin
				if (hit) begin
					if (degenerate) begin
						load_res_seg = 1'b1;
						state_d      = S_DONE;
					end else begin
						load_seg = 1'b1;
						state_d  = S_MUL;
					end
				end else if (idx_q == LAST_SEG) begin
					// Ran off the table: the last pulse width stands.
					load_res_sat = 1'b1;
					state_d      = S_DONE;
				end else begin
					step_idx = 1'b1;
				end
			end
			S_MUL: begin
				state_d = S_START;
			end
			S_START: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (div_rsp.done) begin
					load_res_div = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_q   <= force_q8_8;
			idx_q <= '0;
		end else if (step_idx) begin
			idx_q <= idx_q + 1'b1;
		end

		if (load_seg) begin
			y0_q  <= y_left;
			dy_q  <= dy;
			off_q <= DIFF_W'(off);
			dx_q  <= DIFF_W'(dx);
		end

		// A falling pulse step gives a negative product, which clamps to zero.
		if (state_q == S_MUL) begin
			if (dy_q[DY_W-1]) begin
				num_q <= '0;
			end else begin
				num_q <= NUM_W'(dy_q[PULSE_W-1:0]) * NUM_W'(off_q);
			end
		end

		if (load_res_sat) begin
			res_q <= (state_q == S_IDLE && sat_low) ? BP_PULSE[0] : BP_PULSE[LAST_PT];
		end else if (load_res_seg) begin
			res_q <= y_left;
		end else if (load_res_div) begin
			res_q <= y0_q + div_rsp.quot;
		end
	end

	assign div_req.start = (state_q == S_START);
	assign div_req.num   = num_q;
	assign div_req.den   = dx_q;

	tpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// The result moves to the output register when that register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_pulse_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pulse_us  = out_pulse_q;

	// The divider reports completion only while the sequencer waits on it.
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished outside the wait state");

	// The search never steps past the last segment.
	a_search_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> idx_q <= LAST_SEG)
		else $error("segment search index out of range");

	// An accepted item always starts work on the next cycle.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SEARCH || state_q == S_DONE)
		else $error("accepted item did not start");

	// Every delivered pulse width lies between the two end pulse widths.
	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pulse_us >= BP_PULSE[0] && pulse_us <= BP_PULSE[LAST_PT])
		else $error("pulse width outside the table range");

endmodule
